@@ sv/tgtc_pkg.sv @@
// Shared package for the three-gene tumor-only triple counter.
// Holds field widths, request and register codes, defaults and the walker status struct.
// No dependencies.
`timescale 1ns / 1ps

package tgtc_pkg;

   // Default sizing, handed down as module parameters from the top level
   localparam int MAX_GENES_DEF   = 256;
   localparam int MAX_SAMPLES_DEF = 64;

   // Fixed field widths
   localparam int REQ_TYPE_W    = 2;
   localparam int GENE_W        = 8;
   localparam int SAMPLE_W      = 6;
   localparam int EXPR_W        = 32;
   localparam int COUNT_W       = 22;
   localparam int NUM_GENES_W   = 9;
   localparam int TUMOR_W       = 7;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 9;

   // Request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_LOAD  = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_COUNT = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_GENES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TUMOR     = 2'd1;

   // Register reset values
   localparam logic [NUM_GENES_W-1:0] NUM_GENES_RST = 9'd256;
   localparam logic [TUMOR_W-1:0]     TUMOR_RST     = 7'd32;

   // Status from the triple walker to the top level
   typedef struct packed {
      logic rd_en;
      logic done;
   } tgtc_cnt_sts_type;

endpackage

@@ sv/tgtc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Read during a write to the same address returns the old contents. No dependencies.
`timescale 1ns / 1ps

module tgtc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/tgtc_count.sv @@
// Triple walker: issues one bitmap read per cycle over all gene triples i<j<k
// and accumulates the qualifying count from the returned data. Uses tgtc_pkg.
`timescale 1ns / 1ps

module tgtc_count #(
   parameter int MAX_GENES   = tgtc_pkg::MAX_GENES_DEF,
   parameter int MAX_SAMPLES = tgtc_pkg::MAX_SAMPLES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [$clog2(MAX_GENES+1)-1:0]    n_genes,
   input  logic [MAX_SAMPLES-1:0]            tmask,
   output logic [$clog2(MAX_GENES)-1:0]      rd_addr,
   input  logic [MAX_SAMPLES-1:0]            rd_data,
   output tgtc_pkg::tgtc_cnt_sts_type        sts,
   output logic [tgtc_pkg::COUNT_W-1:0]      total
);

   localparam int AW = $clog2(MAX_GENES);
   localparam int NW = $clog2(MAX_GENES + 1);

   typedef enum logic [4:0] {
      W_IDLE  = 5'b00001,
      W_I     = 5'b00010,
      W_J     = 5'b00100,
      W_K     = 5'b01000,
      W_DRAIN = 5'b10000
   } walk_state_type;

   typedef enum logic [1:0] {
      TAG_NONE = 2'd0,
      TAG_I    = 2'd1,
      TAG_J    = 2'd2,
      TAG_K    = 2'd3
   } rd_tag_type;

   walk_state_type                 state_ff, state_in;
   rd_tag_type                     tag_ff, tag_in;
   logic                           done_ff, done_in;
   logic [NW-1:0]                  i_ff, i_in, j_ff, j_in, k_ff, k_in, n_ff, n_in;
   logic [MAX_SAMPLES-1:0]         tmask_ff, tmask_in;
   logic [MAX_SAMPLES-1:0]         ai_ff, ai_in, pair_ff, pair_in;
   logic [tgtc_pkg::COUNT_W-1:0]   total_ff, total_in;
   logic [MAX_SAMPLES-1:0]         tri_bits;
   logic                           rd_en;

   always_comb begin
      state_in = state_ff;
      tag_in   = TAG_NONE;
      done_in  = 1'b0;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      n_in     = n_ff;
      tmask_in = tmask_ff;
      ai_in    = ai_ff;
      pair_in  = pair_ff;
      total_in = total_ff;
      rd_en    = 1'b0;
      rd_addr  = '0;
      tri_bits = pair_ff & rd_data;

      // returned data, for the address issued in the cycle before
      case (tag_ff)
         TAG_I: ai_in = rd_data;
         TAG_J: pair_in = ai_ff & rd_data;
         TAG_K: begin
            if (((tri_bits & tmask_ff) != '0) && ((tri_bits & ~tmask_ff) == '0) &&
                (total_ff != {tgtc_pkg::COUNT_W{1'b1}})) begin
               total_in = total_ff + 1'b1;
            end
         end
         default: ;
      endcase

      case (state_ff)
         W_IDLE: begin
            if (start) begin
               i_in     = '0;
               n_in     = n_genes;
               tmask_in = tmask;
               total_in = '0;
               state_in = W_I;
            end
         end
         W_I: begin
            if (({1'b0, i_ff} + (NW+1)'(2)) < {1'b0, n_ff}) begin
               rd_en    = 1'b1;
               rd_addr  = i_ff[AW-1:0];
               tag_in   = TAG_I;
               j_in     = i_ff + 1'b1;
               state_in = W_J;
            end else begin
               state_in = W_DRAIN;
            end
         end
         W_J: begin
            rd_en    = 1'b1;
            rd_addr  = j_ff[AW-1:0];
            tag_in   = TAG_J;
            k_in     = j_ff + 1'b1;
            state_in = W_K;
         end
         W_K: begin
            rd_en   = 1'b1;
            rd_addr = k_ff[AW-1:0];
            tag_in  = TAG_K;
            if ((k_ff + 1'b1) == n_ff) begin
               if (({1'b0, j_ff} + (NW+1)'(2)) < {1'b0, n_ff}) begin
                  j_in     = j_ff + 1'b1;
                  state_in = W_J;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = W_I;
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         W_DRAIN: begin
            done_in  = 1'b1;
            state_in = W_IDLE;
         end
         default: state_in = W_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
         tag_ff   <= TAG_NONE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         tag_ff   <= tag_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      n_ff     <= n_in;
      tmask_ff <= tmask_in;
      ai_ff    <= ai_in;
      pair_ff  <= pair_in;
      total_ff <= total_in;
   end

   assign sts.rd_en = rd_en;
   assign sts.done  = done_ff;
   assign total     = total_ff;

endmodule

@@ sv/three_gene_tumor_only_triple_count_top.sv @@
// Top level of the three-gene tumor-only triple counter: request decode, bitmap load
// read-modify-write, clear sweep, result register. Uses tgtc_pkg, tgtc_ram, tgtc_count.
`timescale 1ns / 1ps

// Load and ignored requests: one per cycle while idle; the bitmap write lands in the following cycle.
// Clear request: zero writes over every row, one memory row per cycle, stalled meanwhile.
// Count request: one bitmap read per cycle through the single read port, so requests stall
//    for the whole walk over the gene triples, plus any
//    wait for the result register; the result sits in an output register.
// Reset: control clears at once, then a clearing pass zeroes the
//    bitmap memory while requests stall (register writes are taken throughout).
module three_gene_tumor_only_triple_count_top #(
   parameter int MAX_GENES   = tgtc_pkg::MAX_GENES_DEF,
   parameter int MAX_SAMPLES = tgtc_pkg::MAX_SAMPLES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [tgtc_pkg::REQ_TYPE_W-1:0]      req_type,
   input  logic [tgtc_pkg::GENE_W-1:0]          req_gene_index,
   input  logic [tgtc_pkg::SAMPLE_W-1:0]        req_sample_index,
   input  logic signed [tgtc_pkg::EXPR_W-1:0]   req_expr_value,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [tgtc_pkg::COUNT_W-1:0]         rsp_triple_count,
   // register write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tgtc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tgtc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int AW = $clog2(MAX_GENES);
   localparam int NW = $clog2(MAX_GENES + 1);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_COUNT = 4'b0100,
      ST_HOLD  = 4'b1000
   } top_state_type;

   top_state_type                          state_ff, state_in;
   logic [AW-1:0]                          clr_ff, clr_in;
   logic [tgtc_pkg::NUM_GENES_W-1:0]       num_genes_ff, num_genes_in;
   logic [tgtc_pkg::TUMOR_W-1:0]           tumor_ff, tumor_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [tgtc_pkg::COUNT_W-1:0]           rsp_count_ff, rsp_count_in;

   // load stage: one request in flight between read and write-back
   logic                                   ld_valid_ff, ld_valid_in;
   logic [AW-1:0]                          ld_addr_ff;
   logic [MAX_SAMPLES-1:0]                 ld_bit_ff;
   logic                                   ld_fwd_ff, ld_fwd_in;
   logic [MAX_SAMPLES-1:0]                 last_wdata_ff;

   logic                                   req_acc;
   logic                                   ld_go;
   logic [AW-1:0]                          ld_addr;
   logic [MAX_SAMPLES-1:0]                 ld_bit;
   logic [MAX_SAMPLES-1:0]                 merged;
   logic                                   cnt_start;
   logic [NW-1:0]                          n_eff;
   logic [MAX_SAMPLES-1:0]                 tmask;

   logic                                   ram_wr_en;
   logic [AW-1:0]                          ram_wr_addr;
   logic [MAX_SAMPLES-1:0]                 ram_wr_data;
   logic                                   ram_rd_en;
   logic [AW-1:0]                          ram_rd_addr;
   logic [MAX_SAMPLES-1:0]                 ram_rd_data;

   logic [AW-1:0]                          cnt_rd_addr;
   tgtc_pkg::tgtc_cnt_sts_type             cnt_sts;
   logic [tgtc_pkg::COUNT_W-1:0]           cnt_total;

   // Take requests only when idle; the result register decouples the output side
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Load decode: drop non-positive values and out-of-range gene or sample indexes
   assign ld_go = req_acc && (req_type == tgtc_pkg::REQ_LOAD) &&
                  !req_expr_value[tgtc_pkg::EXPR_W-1] && (req_expr_value != '0) &&
                  (32'(req_gene_index) < MAX_GENES) &&
                  (32'(req_sample_index) < MAX_SAMPLES);
   assign ld_addr = AW'(req_gene_index);
   assign ld_bit  = MAX_SAMPLES'(1) << req_sample_index;

   // Merge the set bit into the row; forward the previous write when it hit the same row
   assign merged = (ld_fwd_ff ? last_wdata_ff : ram_rd_data) | ld_bit_ff;

   assign cnt_start = req_acc && (req_type == tgtc_pkg::REQ_COUNT);

   // Saturate the gene count to the memory depth
   assign n_eff = (32'(num_genes_ff) > MAX_GENES) ? NW'(MAX_GENES) : NW'(num_genes_ff);

   // Tumor samples sit below the threshold; the rest are normal
   always_comb begin
      for (int b = 0; b < MAX_SAMPLES; b++) begin
         tmask[b] = (32'(b) < 32'(tumor_ff));
      end
   end

   // Memory port steering: the sweep owns the write port while clearing
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = ld_valid_ff;
         ram_wr_addr = ld_addr_ff;
         ram_wr_data = merged;
      end
      if (state_ff == ST_COUNT) begin
         ram_rd_en   = cnt_sts.rd_en;
         ram_rd_addr = cnt_rd_addr;
      end else begin
         ram_rd_en   = ld_go;
         ram_rd_addr = ld_addr;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      num_genes_in = num_genes_ff;
      tumor_in     = tumor_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      ld_valid_in  = ld_go;
      ld_fwd_in    = ld_valid_ff && (ld_addr_ff == ld_addr);

      // register writes are taken at any time
      if (csr_valid) begin
         case (csr_index)
            tgtc_pkg::CSR_NUM_GENES: num_genes_in = csr_wdata[tgtc_pkg::NUM_GENES_W-1:0];
            tgtc_pkg::CSR_TUMOR:     tumor_in = csr_wdata[tgtc_pkg::TUMOR_W-1:0];
            default: ;
         endcase
      end

      // retire the result once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == MAX_GENES - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               case (req_type)
                  tgtc_pkg::REQ_CLEAR: begin
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  tgtc_pkg::REQ_COUNT: state_in = ST_COUNT;
                  default: ;
               endcase
            end
         end
         ST_COUNT: begin
            if (cnt_sts.done) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            // hold the total until the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = cnt_total;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         num_genes_ff <= tgtc_pkg::NUM_GENES_RST;
         tumor_ff     <= tgtc_pkg::TUMOR_RST;
         rsp_valid_ff <= 1'b0;
         ld_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         num_genes_ff <= num_genes_in;
         tumor_ff     <= tumor_in;
         rsp_valid_ff <= rsp_valid_in;
         ld_valid_ff  <= ld_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
      ld_addr_ff   <= ld_addr;
      ld_bit_ff    <= ld_bit;
      ld_fwd_ff    <= ld_fwd_in;
      if (ld_valid_ff) begin
         last_wdata_ff <= merged;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_triple_count = rsp_count_ff;

   tgtc_ram #(
      .WIDTH (MAX_SAMPLES),
      .DEPTH (MAX_GENES)
   ) u_bitmaps (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   tgtc_count #(
      .MAX_GENES   (MAX_GENES),
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_count (
      .clock   (clock),
      .reset   (reset),
      .start   (cnt_start),
      .n_genes (n_eff),
      .tmask   (tmask),
      .rd_addr (cnt_rd_addr),
      .rd_data (ram_rd_data),
      .sts     (cnt_sts),
      .total   (cnt_total)
   );

endmodule

@@ sv/tgtc_checker.sv @@
// Port-level checker for the triple counter top level, with its bind statement.
// Uses tgtc_pkg; attaches to three_gene_tumor_only_triple_count_top.
`timescale 1ns / 1ps

module tgtc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic [tgtc_pkg::REQ_TYPE_W-1:0]      req_type,
   input logic [tgtc_pkg::GENE_W-1:0]          req_gene_index,
   input logic [tgtc_pkg::SAMPLE_W-1:0]        req_sample_index,
   input logic signed [tgtc_pkg::EXPR_W-1:0]   req_expr_value,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [tgtc_pkg::COUNT_W-1:0]         rsp_triple_count,
   input logic                                 csr_valid,
   input logic                                 csr_ready,
   input logic [tgtc_pkg::CSR_IDX_W-1:0]       csr_index,
   input logic [tgtc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // A stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_triple_count))
      else $error("result dropped or changed while stalled");

   // A count request keeps the block busy
   a_count_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_type == tgtc_pkg::REQ_COUNT) |=> req_stall)
      else $error("request taken straight after a count request");

   // Requests other than counts (clear, load, spare) never produce a result
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_type != tgtc_pkg::REQ_COUNT) && !rsp_valid
      |=> !rsp_valid)
      else $error("result raised without a count request");

   // Leaving reset: clearing pass stalls requests, no result pending
   a_reset_sweep: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall && !rsp_valid)
      else $error("block not sweeping after reset");

   // Register port is always ready; a write between counts is never refused
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write refused");

endmodule

bind three_gene_tumor_only_triple_count_top tgtc_checker u_tgtc_checker (.*);

@@ tb/sv/tb_three_gene_tumor_only_triple_count_top.sv @@
// Self-checking bench for the three-gene tumor-only triple counter: a clocked driver and
// monitor around the top level, with a bit-accurate mirror of the gene bitmaps and registers.
// Depends on tgtc_pkg and three_gene_tumor_only_triple_count_top.
`timescale 1ns / 1ps

module tb_three_gene_tumor_only_triple_count_top;
   import tgtc_pkg::*;

   localparam int GENE_SLOTS   = MAX_GENES_DEF;
   localparam int SAMPLE_BITS  = MAX_SAMPLES_DEF;
   localparam longint unsigned COUNT_SAT = (64'd1 << COUNT_W) - 1;
   localparam int DRAIN_CYCLES = MAX_GENES_DEF + 16;
   localparam int ITEM_TARGET  = 1600;

   // codes the package leaves unnamed: the spare request type and the spare register slot
   localparam logic [REQ_TYPE_W-1:0] REQ_SPARE = 2'd3;
   localparam logic [CSR_IDX_W-1:0]  CSR_SPARE = 2'd3;

   typedef struct {
      logic [REQ_TYPE_W-1:0]    kind;
      logic [GENE_W-1:0]        gene;
      logic [SAMPLE_W-1:0]      sample;
      logic signed [EXPR_W-1:0] value;
   } bitmap_req_type;

   // ---------------------------------------------------------------- DUT ports
   logic                        clock;
   logic                        reset            = 1'b1;
   logic                        req_valid        = 1'b0;
   logic                        req_stall;
   logic [REQ_TYPE_W-1:0]       req_type         = REQ_CLEAR;
   logic [GENE_W-1:0]           req_gene_index   = '0;
   logic [SAMPLE_W-1:0]         req_sample_index = '0;
   logic signed [EXPR_W-1:0]    req_expr_value   = '0;
   logic                        rsp_valid;
   logic                        rsp_stall        = 1'b0;
   logic [COUNT_W-1:0]          rsp_triple_count;
   logic                        csr_valid        = 1'b0;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index        = '0;
   logic [CSR_DATA_W-1:0]       csr_wdata        = '0;

   three_gene_tumor_only_triple_count_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_gene_index   (req_gene_index),
      .req_sample_index (req_sample_index),
      .req_expr_value   (req_expr_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_triple_count (rsp_triple_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // ---------------------------------------------------------------- mirror state
   // Bitmaps start cleared and the registers at their reset values, as the block does.
   logic [SAMPLE_BITS-1:0] bitmap_mirror [GENE_SLOTS];
   logic [NUM_GENES_W-1:0] mirror_num_genes = NUM_GENES_RST;
   logic [TUMOR_W-1:0]     mirror_tumor     = TUMOR_RST;

   bitmap_req_type     req_queue [$];       // requests waiting for the driver
   logic [COUNT_W-1:0] pending_counts [$];  // triple counts still owed by the block
   bitmap_req_type     held;                // request currently presented on the pins
   bit                 req_taken = 1'b0;
   int                 burst_left = 8;
   int                 gap_left = 0;
   int                 stall_run = 0;
   int                 stall_mode = 0;
   int                 mismatch_total = 0;
   int                 issued = 0;

   initial begin
      for (int g = 0; g < GENE_SLOTS; g++) bitmap_mirror[g] = '0;
   end

   // ---------------------------------------------------------------- clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard limit: the slowest legal run is dominated by the one full-size count;
   // allow several times its length.
   initial begin
      #(200_000_000);
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------- predictor
   // Walk every triple i<j<k below the effective gene count and count those whose
   // common samples hold a tumor bit and no normal bit. Skip pairs with no shared
   // tumor bit early; this cannot change the total.
   function automatic logic [COUNT_W-1:0] count_tumor_triples();
      int                     n;
      logic [SAMPLE_BITS-1:0] tmask;
      logic [SAMPLE_BITS-1:0] pair;
      logic [SAMPLE_BITS-1:0] common;
      longint unsigned        total;
      n     = (mirror_num_genes > GENE_SLOTS) ? GENE_SLOTS : int'(mirror_num_genes);
      tmask = (mirror_tumor >= SAMPLE_BITS) ? '1 : ((64'd1 << mirror_tumor) - 64'd1);
      total = 0;
      for (int i = 0; i < n; i++) begin
         for (int j = i + 1; j < n; j++) begin
            pair = bitmap_mirror[i] & bitmap_mirror[j];
            if ((pair & tmask) != '0) begin
               for (int k = j + 1; k < n; k++) begin
                  common = pair & bitmap_mirror[k];
                  if ((common & tmask) != '0 && (common & ~tmask) == '0) total++;
               end
            end
         end
      end
      if (total > COUNT_SAT) total = COUNT_SAT;
      return total[COUNT_W-1:0];
   endfunction

   // Apply one accepted request to the mirror; a count owes one result.
   function automatic void apply_request(bitmap_req_type r);
      case (r.kind)
         REQ_CLEAR: begin
            for (int g = 0; g < GENE_SLOTS; g++) bitmap_mirror[g] = '0;
         end
         REQ_LOAD: begin
            if (r.value > 0) bitmap_mirror[r.gene][r.sample] = 1'b1;
         end
         REQ_COUNT: begin
            pending_counts.push_back(count_tumor_triples());
         end
         default: ;
      endcase
   endfunction

   function automatic void push_req(logic [REQ_TYPE_W-1:0] kind, logic [GENE_W-1:0] gene,
                                    logic [SAMPLE_W-1:0] sample, logic [EXPR_W-1:0] value);
      bitmap_req_type r;
      r.kind   = kind;
      r.gene   = gene;
      r.sample = sample;
      r.value  = value;
      req_queue.push_back(r);
      issued++;
   endfunction

   function automatic logic [EXPR_W-1:0] positive_value();
      return EXPR_W'($urandom_range(1, 32'h7FFF_FFFF));
   endfunction

   // Zero, the most negative value, or any other negative value.
   function automatic logic [EXPR_W-1:0] non_positive_value();
      case ($urandom_range(0, 2))
         0:       return '0;
         1:       return 32'h8000_0000;
         default: return {1'b1, 31'($urandom)};
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [COUNT_W-1:0] got,
                                  logic [COUNT_W-1:0] want);
      $display("mismatch at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
      mismatch_total++;
   endtask

   // ---------------------------------------------------------------- request driver
   // Take the request at the rising edge on valid and no stall, and predict from it.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         apply_request(held);
         req_taken = 1'b1;
      end
   end

   // Drive at the falling edge: hold a stalled request, otherwise advance to the next
   // one or idle. Bursts of random length are separated by random gaps, and roughly a
   // quarter of the bursts run straight into the next one with no gap at all.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (req_queue.size() != 0) begin
            held = req_queue.pop_front();
            req_valid        <= 1'b1;
            req_type         <= held.kind;
            req_gene_index   <= held.gene;
            req_sample_index <= held.sample;
            req_expr_value   <= held.value;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- result side
   // Stall on a pattern of our own: stretches of no stall, light random stall and
   // heavy random stall, each lasting a random number of cycles.
   always @(negedge clock) begin
      if (stall_run == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_run  = $urandom_range(20, 200);
      end else begin
         stall_run--;
      end
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 2) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // Compare each accepted result with the oldest count still owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_counts.size() == 0) begin
            report_mismatch("result with no count request outstanding", rsp_triple_count, '0);
         end else begin
            if (rsp_triple_count !== pending_counts[0])
               report_mismatch("triple_count", rsp_triple_count, pending_counts[0]);
            void'(pending_counts.pop_front());
         end
      end
   end

   // ---------------------------------------------------------------- register writes
   // Only called while no request is pending or in flight, so the mirror can follow at once.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_NUM_GENES: mirror_num_genes = data[NUM_GENES_W-1:0];
         CSR_TUMOR:     mirror_tumor     = data[TUMOR_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Hold off until every queued request is taken and every count has come back, then
   // give a clear sweep or trailing load time to finish before anything changes.
   task automatic wait_idle();
      do @(posedge clock);
      while (req_queue.size() != 0 || req_valid || pending_counts.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- stimulus
   initial begin
      int       ng;
      int       ng_eff;
      int       tumor_span;
      int       nloads;
      int       g;
      int       s;
      int       hot [3];
      int       sweep_ng [8];
      int       sweep_ts [8];

      // Hold reset, then release it; the block then clears its memory on its own.
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: four genes, samples 0 and 1 tumor.
      write_reg(CSR_NUM_GENES, 9'd4);
      write_reg(CSR_TUMOR, 9'd2);
      wait_idle();
      push_req(REQ_CLEAR, 8'd0, 6'd0, 32'd0);
      push_req(REQ_LOAD, 8'd0, 6'd0, 32'd1);
      push_req(REQ_LOAD, 8'd1, 6'd0, 32'h7FFF_FFFF);
      push_req(REQ_LOAD, 8'd2, 6'd0, 32'd5);
      // values at or below zero leave the bitmap alone
      push_req(REQ_LOAD, 8'd3, 6'd1, 32'hFFFF_FFFF);
      push_req(REQ_LOAD, 8'd3, 6'd0, 32'd0);
      push_req(REQ_LOAD, 8'd3, 6'd63, 32'h8000_0000);
      push_req(REQ_COUNT, 8'd0, 6'd0, 32'd0);
      push_req(REQ_LOAD, 8'd3, 6'd0, 32'd1);
      // a normal sample shared by genes 0..2 disqualifies their triple
      push_req(REQ_LOAD, 8'd2, 6'd5, 32'd3);
      push_req(REQ_LOAD, 8'd0, 6'd5, 32'd3);
      push_req(REQ_LOAD, 8'd1, 6'd5, 32'd3);
      push_req(REQ_COUNT, 8'd0, 6'd0, 32'd0);
      // spare request code: nothing changes and nothing comes back
      push_req(REQ_SPARE, 8'hFF, 6'h3F, 32'hFFFF_FFFF);
      push_req(REQ_LOAD, 8'd255, 6'd63, 32'h7FFF_FFFF);
      push_req(REQ_LOAD, 8'd3, 6'd1, 32'd9);
      push_req(REQ_COUNT, 8'hFF, 6'h3F, 32'hFFFF_FFFF);
      wait_idle();

      // Sweep the registers over the same bitmaps: no genes, too few genes, no tumor
      // samples, all samples tumor (64, 127 and a write with the upper data bits set).
      sweep_ng = '{0, 2, 3, 3, 3, 4, 4, 4};
      sweep_ts = '{32, 32, 0, 64, 127, 1, 9'h1C0, 6};
      for (int p = 0; p < 8; p++) begin
         write_reg(CSR_NUM_GENES, CSR_DATA_W'(sweep_ng[p]));
         write_reg(CSR_TUMOR, CSR_DATA_W'(sweep_ts[p]));
         if (p == 7) write_reg(CSR_SPARE, 9'h1FF);
         push_req(REQ_COUNT, 8'd0, 6'd0, 32'd0);
         wait_idle();
      end
      push_req(REQ_CLEAR, 8'd0, 6'd0, 32'd0);
      push_req(REQ_COUNT, 8'd0, 6'd0, 32'd0);
      wait_idle();

      // One full-size count: gene count written past the maximum so it saturates, every
      // gene present in tumor sample 0 and a few also in the last (normal) sample.
      write_reg(CSR_NUM_GENES, 9'd511);
      write_reg(CSR_TUMOR, 9'd63);
      push_req(REQ_CLEAR, 8'd0, 6'd0, 32'd0);
      for (int k = 0; k < GENE_SLOTS; k++)
         push_req(REQ_LOAD, GENE_W'(k), 6'd0, positive_value());
      for (int k = 0; k < 6; k++)
         push_req(REQ_LOAD, GENE_W'($urandom_range(0, 255)), 6'd63, positive_value());
      push_req(REQ_COUNT, 8'd0, 6'd0, 32'd0);
      wait_idle();

      // Random phases until the request budget is spent. Each picks registers, then
      // mostly builds bitmaps from a few hot samples so that triples qualify, and ends
      // on a count; the rest is noise.
      while (issued < ITEM_TARGET) begin
         case ($urandom_range(0, 19))
            0:       ng = $urandom_range(0, 2);
            1, 2:    ng = $urandom_range(17, 40);
            default: ng = $urandom_range(3, 16);
         endcase
         if ($urandom_range(0, 3) != 0 || ng > 16)
            write_reg(CSR_NUM_GENES, CSR_DATA_W'(ng));
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
               0:       write_reg(CSR_TUMOR, 9'd0);
               1:       write_reg(CSR_TUMOR, CSR_DATA_W'($urandom_range(64, 511)));
               default: write_reg(CSR_TUMOR, CSR_DATA_W'($urandom_range(1, 63)));
            endcase
         end
         ng_eff     = (mirror_num_genes > GENE_SLOTS) ? GENE_SLOTS : int'(mirror_num_genes);
         tumor_span = (mirror_tumor >= SAMPLE_BITS) ? SAMPLE_BITS : int'(mirror_tumor);

         if ($urandom_range(0, 19) < 17) begin
            if ($urandom_range(0, 2) != 0) push_req(REQ_CLEAR, 8'd0, 6'd0, 32'd0);
            foreach (hot[h])
               hot[h] = (tumor_span > 0) ? $urandom_range(0, tumor_span - 1)
                                         : $urandom_range(0, 63);
            nloads = $urandom_range(8, 60);
            for (int k = 0; k < nloads; k++) begin
               if ($urandom_range(0, 19) == 0) begin
                  push_req(REQ_SPARE, GENE_W'($urandom), SAMPLE_W'($urandom), $urandom);
               end else if ($urandom_range(0, 24) == 0) begin
                  push_req(REQ_COUNT, GENE_W'($urandom), SAMPLE_W'($urandom), $urandom);
               end else begin
                  g = (ng_eff > 0 && $urandom_range(0, 9) != 0)
                      ? $urandom_range(0, ng_eff - 1) : $urandom_range(0, 255);
                  s = ($urandom_range(0, 3) != 0) ? hot[$urandom_range(0, 2)]
                                                  : $urandom_range(0, 63);
                  push_req(REQ_LOAD, GENE_W'(g), SAMPLE_W'(s),
                           ($urandom_range(0, 7) != 0) ? positive_value()
                                                       : non_positive_value());
               end
            end
         end else begin
            nloads = $urandom_range(5, 30);
            for (int k = 0; k < nloads; k++)
               push_req(REQ_TYPE_W'($urandom_range(0, 3)), GENE_W'($urandom),
                        SAMPLE_W'($urandom),
                        ($urandom_range(0, 1) != 0) ? positive_value() : $urandom);
         end
         push_req(REQ_COUNT, 8'd0, 6'd0, 32'd0);
         // every phase drains completely before the registers move again
         wait_idle();
      end

      if (mismatch_total == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
